// ===== rtl/xtea_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA encrypt package
// Shared types and constants for the pipelined XTEA encipher block.
// ----------------------------------------------------------------------------
package xtea_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ID_W      = 64;
    localparam int unsigned KEY_COUNT = 4;
    localparam int unsigned KSEL_W    = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned MAX_ROUNDS = 64;

    localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_3 = 3'd3;

    typedef logic [WORD_W-1:0] t_word;

    typedef t_word t_key_set [KEY_COUNT];

    // One item in flight: v0 is the first half, v1 the second.
    typedef struct packed {
        t_word v1;
        t_word v0;
    } t_halves;

    // Running round total after a given number of rounds.
    function automatic t_word round_total(input int unsigned rounds_done);
        t_word acc;
        acc = '0;
        for (int unsigned k = 0; k < MAX_ROUNDS + 1; k++) begin
            if (k < rounds_done) begin
                acc = acc + DELTA;
            end
        end
        return acc;
    endfunction

endpackage

// ===== rtl/xtea_plain_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plain identifier channel
// Valid/ready channel that carries one identifier request to be enciphered.
// ----------------------------------------------------------------------------
interface xtea_plain_if;
    logic        valid;
    logic        ready;
    logic [63:0] plain_id;

    modport source (output valid, output plain_id, input ready);
    modport sink   (input valid, input plain_id, output ready);
endinterface

// ===== rtl/xtea_cipher_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cipher identifier channel
// Valid/ready channel that carries one enciphered identifier request.
// ----------------------------------------------------------------------------
interface xtea_cipher_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_id;

    modport source (output valid, output cipher_id, input ready);
    modport sink   (input valid, input cipher_id, output ready);
endinterface

// ===== rtl/xtea_keys.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA key registers
// Four 32-bit key words written through the configuration port.
// ----------------------------------------------------------------------------
module xtea_keys
    import xtea_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    output t_key_set             o_keys
);

    t_word r_key [KEY_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_key[k] <= '0;
            end
        end else if (i_cfg_we && i_cfg_idx <= REG_KEY_3) begin
            r_key[i_cfg_idx[KSEL_W-1:0]] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int k = 0; k < KEY_COUNT; k++) begin
            o_keys[k] = r_key[k];
        end
    end

    a_oob_write_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx > REG_KEY_3) |=>
            ($stable(r_key[0]) && $stable(r_key[1]) && $stable(r_key[2]) && $stable(r_key[3])))
        else $error("key changed on out-of-range write");

    a_key0_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == REG_KEY_0) |=> (r_key[0] == $past(i_cfg_data)))
        else $error("key word zero not taken");

    a_keys_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_we |=>
            ($stable(r_key[0]) && $stable(r_key[1]) && $stable(r_key[2]) && $stable(r_key[3])))
        else $error("key changed without a write");

endmodule

// ===== rtl/xtea_half.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA half-round stage
// One registered half of an XTEA round; the running total is fixed per stage.
// ----------------------------------------------------------------------------
module xtea_half
    import xtea_pkg::*;
#(
    parameter logic [31:0] TOTAL  = 32'h0,
    parameter bit          SECOND = 1'b0
)(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_halves  i_data,
    input  t_key_set i_keys,
    output logic     o_valid,
    output t_halves  o_data
);

    // The first half picks its key by total bits 1:0, the second by 12:11.
    localparam logic [KSEL_W-1:0] KSEL = SECOND ? TOTAL[12:11] : TOTAL[1:0];

    logic    r_valid;
    t_halves r_data;
    t_halves n_data;
    t_word   w_src;
    t_word   w_mix;
    t_word   w_tk;

    always_comb begin
        w_src  = SECOND ? i_data.v0 : i_data.v1;
        w_tk   = TOTAL + i_keys[KSEL];
        w_mix  = (((w_src << 4) ^ (w_src >> 5)) + w_src) ^ w_tk;
        n_data = i_data;
        if (SECOND) begin
            n_data.v1 = i_data.v1 + w_mix;
        end else begin
            n_data.v0 = i_data.v0 + w_mix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/xtea_encrypt_64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA encrypt, 64-bit identifier
// Fully pipelined XTEA encipher: one half-round per register stage.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Payload                  | Handshake
//  i_plain   | in        | plain_id  [63:0]         | valid / ready
//  o_cipher  | out       | cipher_id [63:0]         | valid / ready
//  i_cfg_*   | in        | idx [2:0], data [31:0]   | write enable, no wait
//
// One register stage per half-round; a new request is accepted every cycle
// unless the output stalls. The last stage is the output register.
// A stalled output freezes every stage at once, and input ready drops with it.
// Reset clears the stage valid bits and the key words to zero.
// ----------------------------------------------------------------------------
module xtea_encrypt_64
    import xtea_pkg::*;
#(
    parameter int unsigned ROUNDS = 32
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    xtea_plain_if.sink           i_plain,
    xtea_cipher_if.source        o_cipher,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    localparam int unsigned STAGES = 2 * ROUNDS;

    t_key_set           w_keys;
    logic               w_en;
    logic [STAGES-1:0]  w_vld;
    t_halves            w_data [STAGES+1];

    xtea_keys u_keys (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_keys     (w_keys)
    );

    // The whole pipe advances unless a finished result is held at the output.
    assign w_en = !w_vld[STAGES-1] || o_cipher.ready;

    assign w_data[0].v0 = i_plain.plain_id[31:0];
    assign w_data[0].v1 = i_plain.plain_id[63:32];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam bit          SEC = (s % 2) == 1;
        localparam logic [31:0] TOT = round_total(s / 2 + s % 2);
        logic w_in_vld;

        if (s == 0) begin : g_first
            assign w_in_vld = i_plain.valid;
        end else begin : g_rest
            assign w_in_vld = w_vld[s-1];
        end

        xtea_half #(
            .TOTAL  (TOT),
            .SECOND (SEC)
        ) u_half (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_in_vld),
            .i_data  (w_data[s]),
            .i_keys  (w_keys),
            .o_valid (w_vld[s]),
            .o_data  (w_data[s+1])
        );
    end

    assign i_plain.ready      = w_en;
    assign o_cipher.valid     = w_vld[STAGES-1];
    assign o_cipher.cipher_id = {w_data[STAGES].v1, w_data[STAGES].v0};

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cipher.valid && !o_cipher.ready) |=> $stable(w_vld))
        else $error("pipeline moved during an output stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_plain.valid && i_plain.ready) |=> w_vld[0])
        else $error("accepted request did not enter the first stage");

    a_tail_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |=> (w_vld[STAGES-1] == $past(w_vld[STAGES-2])))
        else $error("output valid did not follow the previous stage");

endmodule

// ===== verif/tb_xtea_encrypt_64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA encrypt regression bench
// Feeds identifiers through the pipelined XTEA encipher block under a series
// of key settings and checks every enciphered identifier, in order, against
// a behavioral XTEA computed on the bench side. The channels pause at random in some phases.
// ----------------------------------------------------------------------------
module tb_xtea_encrypt_64
    import xtea_pkg::*;
;

    localparam int unsigned ROUND_COUNT     = 32;
    localparam int unsigned LATENCY         = 2 * ROUND_COUNT;
    localparam int unsigned PHASES          = 8;
    localparam int unsigned ITEMS_PER_PHASE = 160;
    localparam int unsigned DIRECTED_COUNT  = 16;
    localparam int unsigned PRINT_CAP       = 100;

    // Indexes past the last key word exist on the port but select nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_KEY_3 + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

    typedef struct packed {
        logic [ID_W-1:0] plain_id;
        logic [ID_W-1:0] cipher_id;
    } t_cipher_due;

    // Keeps the bench copy of the key and the enciphered identifiers still owed.
    class cipher_ledger;
        t_word       key_words [KEY_COUNT];
        t_cipher_due owed [$];
        int          mismatch_count;

        function new();
            foreach (key_words[k]) key_words[k] = '0;
            mismatch_count = 0;
        endfunction

        function void apply_key(logic [CFG_IDX_W-1:0] idx, t_word data);
            if (idx <= REG_KEY_3) begin
                key_words[idx[KSEL_W-1:0]] = data;
            end
        endfunction

        function t_word mix_half(t_word src, t_word total, t_word key_word);
            return (((src << 4) ^ (src >> 5)) + src) ^ (total + key_word);
        endfunction

        function logic [ID_W-1:0] encipher(logic [ID_W-1:0] plain_id);
            t_halves h;
            t_word   total;
            h     = plain_id;
            total = '0;
            for (int r = 0; r < ROUND_COUNT; r++) begin
                h.v0  = h.v0 + mix_half(h.v1, total, key_words[total[1:0]]);
                total = total + DELTA;
                h.v1  = h.v1 + mix_half(h.v0, total, key_words[total[12:11]]);
            end
            return h;
        endfunction

        function void note_plain(logic [ID_W-1:0] plain_id);
            t_cipher_due due;
            due.plain_id  = plain_id;
            due.cipher_id = encipher(plain_id);
            owed.push_back(due);
        endfunction

        task report_mismatch(string what);
            if (mismatch_count < PRINT_CAP) begin
                $display("[%0t] MISMATCH %s", $realtime, what);
            end
            mismatch_count++;
        endtask

        task check_cipher(logic [ID_W-1:0] got);
            t_cipher_due due;
            if (owed.size() == 0) begin
                report_mismatch($sformatf("unexpected cipher_id %h", got));
            end else begin
                due = owed.pop_front();
                if (got !== due.cipher_id) begin
                    report_mismatch($sformatf("cipher_id for plain %h: expected %h got %h",
                                              due.plain_id, due.cipher_id, got));
                end
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [WORD_W-1:0]    i_cfg_data;

    xtea_plain_if  plain_ch ();
    xtea_cipher_if cipher_ch ();

    cipher_ledger ledger = new();
    bit           source_steady;
    bit           sink_steady;
    t_word        key_plan [KEY_COUNT];

    xtea_encrypt_64 #(
        .ROUNDS (ROUND_COUNT)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_plain    (plain_ch),
        .o_cipher   (cipher_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mostly no pause or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic t_word pick_word();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return 32'h8000_0000;
        if (r == 3) return 32'h0000_0001;
        return $urandom();
    endfunction

    function automatic logic [ID_W-1:0] directed_id(int n);
        case (n)
            0:       return 64'h0000_0000_0000_0000;
            1:       return 64'hFFFF_FFFF_FFFF_FFFF;
            2:       return 64'h0000_0000_FFFF_FFFF;
            3:       return 64'hFFFF_FFFF_0000_0000;
            4:       return 64'h0000_0000_0000_0001;
            5:       return 64'h0000_0001_0000_0000;
            6:       return 64'h8000_0000_0000_0000;
            7:       return 64'h0000_0000_8000_0000;
            8:       return 64'h5555_5555_AAAA_AAAA;
            9:       return 64'hAAAA_AAAA_5555_5555;
            10:      return 64'h0123_4567_89AB_CDEF;
            11:      return 64'h7FFF_FFFF_7FFF_FFFF;
            12:      return 64'h8000_0000_8000_0000;
            13:      return 64'hFEDC_BA98_7654_3210;
            14:      return 64'h0000_000F_F000_0000;
            default: return 64'h1234_5678_9ABC_DEF0;
        endcase
    endfunction

    // Leaves valid high on return so that a back-to-back request needs no toggle.
    task automatic send_plain(input logic [ID_W-1:0] id);
        int gap;
        gap = source_steady ? 0 : pick_gap();
        if (gap > 0) begin
            plain_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        plain_ch.valid    <= 1'b1;
        plain_ch.plain_id <= id;
        @(posedge i_clk);
        while (!plain_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain_pipeline();
        plain_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (ledger.owed.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_word data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        ledger.apply_key(idx, data);
    endtask

    // A write to an unused index lands between the key words when asked for.
    task automatic load_keys(input bit with_spare);
        for (int k = 0; k < KEY_COUNT; k++) begin
            write_reg(REG_KEY_0 + CFG_IDX_W'(k), key_plan[k]);
            if (with_spare && k == 1) begin
                write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                          $urandom());
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count, input bit pause_midway);
        for (int n = 0; n < count; n++) begin
            if (pause_midway && n == count / 2) begin
                drain_pipeline();
            end
            send_plain({pick_word(), pick_word()});
        end
        drain_pipeline();
    endtask

    // Every request and every enciphered identifier passes through the ledger.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (plain_ch.valid && plain_ch.ready) begin
                ledger.note_plain(plain_ch.plain_id);
            end
            if (cipher_ch.valid && cipher_ch.ready) begin
                ledger.check_cipher(cipher_ch.cipher_id);
            end
        end
    end

    initial begin : sink_pacing
        int gap;
        cipher_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (sink_steady) begin
                cipher_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                cipher_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    cipher_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : watchdog
        #3_000_000;
        $display("xtea_encrypt_64 regression: fail");
        $finish;
    end

    initial begin : stimulus
        source_steady = 1'b0;
        sink_steady   = 1'b0;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= REG_KEY_0;
        i_cfg_data        <= '0;
        plain_ch.valid    <= 1'b0;
        plain_ch.plain_id <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed identifiers run under the all-zero key left by reset.
        for (int n = 0; n < DIRECTED_COUNT; n++) begin
            send_plain(directed_id(n));
        end
        run_random(ITEMS_PER_PHASE, 1'b0);

        for (int phase = 1; phase < PHASES; phase++) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                case (phase)
                    1:       key_plan[k] = '1;
                    2:       key_plan[k] = k[0] ? '1 : '0;
                    3:       key_plan[k] = k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    default: key_plan[k] = pick_word();
                endcase
            end
            load_keys(phase == 3 || $urandom_range(0, 1) == 1);
            source_steady = (phase % 3 == 1) || (phase % 3 == 2);
            sink_steady   = (phase % 3 == 1);
            run_random(ITEMS_PER_PHASE, phase == 4);
        end

        repeat (LATENCY + 8) @(posedge i_clk);
        if (ledger.mismatch_count == 0) begin
            $display("xtea_encrypt_64 regression: pass");
        end else begin
            $display("xtea_encrypt_64 regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/xtea_pkg.sv
rtl/xtea_plain_if.sv
rtl/xtea_cipher_if.sv
rtl/xtea_keys.sv
rtl/xtea_half.sv
rtl/xtea_encrypt_64.sv
verif/tb_xtea_encrypt_64.sv
